@@ hdl/sat_pkg.sv @@
// Shared types, constants and request/status codes for the sorted array table.
package sat_pkg;

  // Table geometry
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Request types
  localparam logic [1:0] REQ_INSERT     = 2'd0;
  localparam logic [1:0] REQ_REMOVE_VAL = 2'd1;
  localparam logic [1:0] REQ_REMOVE_IDX = 2'd2;
  localparam logic [1:0] REQ_READ       = 2'd3;

  // Result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  // Per-cell update operation
  localparam logic [1:0] OP_HOLD     = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_SHIFT_UP = 2'd2;
  localparam logic [1:0] OP_SHIFT_DN = 2'd3;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic [1:0] op;
    logic       cmp_en;
  } cell_ctl_t;

  // Registered compare flags from each cell
  typedef struct packed {
    logic lt;   // stored entry comes before the value in the current order
    logic eq;   // stored entry equals the value
  } cell_flag_t;

endpackage

@@ hdl/sat_cell.sv @@
// One storage cell of the sorted chain: holds an entry, compares it, shifts.
module sat_cell (
  input  logic                clk,
  input  sat_pkg::cell_ctl_t  ctl,
  input  logic                desc,
  input  sat_pkg::data_t      cmp_value,
  input  sat_pkg::data_t      load_value,
  input  sat_pkg::data_t      left_entry,
  input  sat_pkg::data_t      right_entry,
  output sat_pkg::data_t      entry,
  output sat_pkg::cell_flag_t flag
);
  import sat_pkg::*;

  data_t      entry_r;
  data_t      entry_nxt;
  cell_flag_t flag_r;
  cell_flag_t flag_nxt;

  // Compare against the incoming value in the transaction's accept cycle
  always_comb begin
    flag_nxt    = flag_r;
    if (ctl.cmp_en) begin
      flag_nxt.lt = desc ? (cmp_value < entry_r) : (entry_r < cmp_value);
      flag_nxt.eq = (entry_r == cmp_value);
    end
  end

  // Entry update: keep, take the new value, or take a neighbor's entry
  always_comb begin
    case (ctl.op)
      OP_HOLD:     entry_nxt = entry_r;
      OP_LOAD:     entry_nxt = load_value;
      OP_SHIFT_UP: entry_nxt = left_entry;
      OP_SHIFT_DN: entry_nxt = right_entry;
      default:     entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    flag_r  <= flag_nxt;
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule

@@ hdl/sorted_array_table_core.sv @@
// Top level of the sorted array table: request sequencer over a chain of cells.
// A transaction has an accept and an execute cycle: in the accept cycle every
// cell compares its entry with the incoming value and registers the result; in
// the execute cycle, which waits while a held result stalls on out_stall, the
// sequencer finds the insert or removal point from those flags and every cell
// loads, shifts or holds at once, while the result is written to the output
// register. in_stall is high throughout the execute state, so a new transaction
// is not taken until the previous one has executed, also while a result waits
// on out_stall. The order register may be written at any time the block is
// idle (cfg_ready is always high). The table holds up to sixteen entries; no
// clearing pass is run after reset.
module sorted_array_table_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_req_type,
  input  sat_pkg::data_t        in_value,
  input  sat_pkg::idx_t         in_position,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output sat_pkg::data_t        out_read_value,
  output sat_pkg::cnt_t         out_entry_count,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_order_descending
);
  import sat_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic       state_r, state_nxt;
  logic       desc_r;
  logic [1:0] req_type_r;
  data_t      value_r;
  idx_t       position_r;
  cnt_t       count_r, count_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  data_t      out_read_value_r, out_read_value_nxt;
  cnt_t       out_entry_count_r, out_entry_count_nxt;

  logic in_accept;
  logic out_free;
  logic do_exec;

  data_t      entry_vec [CAPACITY];
  cell_flag_t flag_vec  [CAPACITY];
  cell_ctl_t  ctl_vec   [CAPACITY];

  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] stop_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] sel_vec;
  logic [CAPACITY-1:0] prior_vec;   // a selected cell lies below this one

  logic is_full;
  logic any_match;
  logic pos_ok;

  // Handshake
  assign in_stall  = (state_r == S_EXEC);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign do_exec   = (state_r == S_EXEC) && out_free;
  assign cfg_ready = 1'b1;

  // Per-cell qualifiers from the registered compare flags
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_vec[i] = (CNT_W'(i) < count_r);
      stop_vec[i]  = !(valid_vec[i] && flag_vec[i].lt);
      match_vec[i] = valid_vec[i] && flag_vec[i].eq;
    end
  end

  assign sel_vec   = (req_type_r == REQ_INSERT) ? stop_vec : match_vec;
  assign is_full   = (count_r == CNT_W'(CAPACITY));
  assign any_match = |match_vec;
  assign pos_ok    = (CNT_W'(position_r) < count_r);

  // Prior-selection mask per cell: OR over all lower cells, computed in parallel
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      prior_vec[i] = |(sel_vec & ({CAPACITY{1'b1}} >> (CAPACITY - i)));
    end
  end

  // Cell operations
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ctl_vec[i].cmp_en = in_accept;
      ctl_vec[i].op     = OP_HOLD;
      if (do_exec) begin
        case (req_type_r)
          REQ_INSERT: begin
            if (!is_full) begin
              if (sel_vec[i] && !prior_vec[i]) begin
                ctl_vec[i].op = OP_LOAD;
              end else if (prior_vec[i] && (CNT_W'(i) <= count_r)) begin
                ctl_vec[i].op = OP_SHIFT_UP;
              end
            end
          end
          REQ_REMOVE_VAL: begin
            if (sel_vec[i] || prior_vec[i]) begin
              ctl_vec[i].op = OP_SHIFT_DN;
            end
          end
          REQ_REMOVE_IDX: begin
            if (pos_ok && (IDX_W'(i) >= position_r)) begin
              ctl_vec[i].op = OP_SHIFT_DN;
            end
          end
          REQ_READ: ctl_vec[i].op = OP_HOLD;
          default:  ctl_vec[i].op = OP_HOLD;
        endcase
      end
    end
  end

  // The cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    data_t left_entry;
    data_t right_entry;
    if (g == 0) begin : g_first
      assign left_entry = '0;
    end else begin : g_mid_l
      assign left_entry = entry_vec[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid_r
      assign right_entry = entry_vec[g+1];
    end
    sat_cell u_cell (
      .clk         (clk),
      .ctl         (ctl_vec[g]),
      .desc        (desc_r),
      .cmp_value   (in_value),
      .load_value  (value_r),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_vec[g]),
      .flag        (flag_vec[g])
    );
  end

  // Sequencer, count and result register
  always_comb begin
    state_nxt           = state_r;
    count_nxt           = count_r;
    out_valid_nxt       = out_valid_r && out_stall;
    out_status_nxt      = out_status_r;
    out_read_value_nxt  = out_read_value_r;
    out_entry_count_nxt = out_entry_count_r;
    if (in_accept) begin
      state_nxt = S_EXEC;
    end
    if (do_exec) begin
      state_nxt          = S_IDLE;
      out_valid_nxt      = 1'b1;
      out_status_nxt     = ST_OK;
      out_read_value_nxt = '0;
      case (req_type_r)
        REQ_INSERT: begin
          if (is_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        REQ_REMOVE_VAL: begin
          if (any_match) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        REQ_REMOVE_IDX: begin
          if (pos_ok) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            out_status_nxt = ST_RANGE;
          end
        end
        REQ_READ: begin
          if (pos_ok) begin
            out_read_value_nxt = entry_vec[position_r];
          end else begin
            out_status_nxt = ST_RANGE;
          end
        end
        default: out_status_nxt = ST_OK;
      endcase
      out_entry_count_nxt = count_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        desc_r <= cfg_order_descending;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_type_r <= in_req_type;
      value_r    <= in_value;
      position_r <= in_position;
    end
    out_status_r      <= out_status_nxt;
    out_read_value_r  <= out_read_value_nxt;
    out_entry_count_r <= out_entry_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_entry_count = out_entry_count_r;

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      ((count_r == $past(count_r) + CNT_W'(1)) || (count_r + CNT_W'(1) == $past(count_r))))
    else $error("entry count moved by more than one");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == ST_FULL)) |-> (out_entry_count_r == CNT_W'(CAPACITY)))
    else $error("full status with spare room");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_read_value_r == '0))
    else $error("failed request returned a nonzero value");

  a_count_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !do_exec |=> (count_r == $past(count_r)))
    else $error("entry count changed outside execute cycle");

endmodule

@@ tb/sv/sorted_array_table_core_tb.sv @@
// Self-checking testbench for the sorted array table core: directed table plus random traffic.
`timescale 1ns / 100ps

module sorted_array_table_core_tb;
  import sat_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 300;

  typedef struct {
    logic [1:0] status;
    data_t      read_value;
    logic [4:0] entry_count;
  } result_t;

  typedef struct {
    logic [1:0] req;
    data_t      value;
    logic [3:0] position;
    bit         given;
    result_t    want;
  } plan_step_t;

  // DUT ports
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_req_type = REQ_INSERT;
  data_t      in_value = '0;
  logic [3:0] in_position = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  data_t      out_read_value;
  logic [4:0] out_entry_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_order_descending = 1'b0;

  // Expectation typed into the plan, travels with the transaction
  bit         want_given = 1'b0;
  result_t    want_result;

  // Shadow copy of the table
  data_t      shadow_entries [CAPACITY];
  int         shadow_count = 0;
  logic       shadow_desc = 1'b0;

  result_t    pending_results [$];
  plan_step_t plan [$];
  data_t      fill_vals [12] = '{-3, 100, -2147483647, 42, 42, 7, -100, 5, 1, 2147483646, -7, 9};

  int         errors = 0;
  int         cycles = 0;
  int         hold_left = 0;
  bit         steady = 1'b0;

  sorted_array_table_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_value             (in_value),
    .in_position          (in_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_read_value       (out_read_value),
    .out_entry_count      (out_entry_count),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_order_descending (cfg_order_descending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Entry e sorts ahead of value v in the current order
  function automatic bit sorts_ahead(data_t e, data_t v);
    return shadow_desc ? (v < e) : (e < v);
  endfunction

  function automatic void drop_entry(int idx);
    int i;
    for (i = idx; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
    shadow_count--;
  endfunction

  // Apply one request to the shadow table and return its result
  function automatic result_t apply_request(logic [1:0] req, data_t val, logic [3:0] pos);
    result_t r;
    int at;
    int i;
    r.status = ST_OK;
    r.read_value = '0;
    case (req)
      REQ_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          at = 0;
          while (at < shadow_count && sorts_ahead(shadow_entries[at], val)) at++;
          for (i = shadow_count; i > at; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[at] = val;
          shadow_count++;
        end
      end
      REQ_REMOVE_VAL: begin
        at = 0;
        while (at < shadow_count && shadow_entries[at] != val) at++;
        if (at >= shadow_count) r.status = ST_NOT_FOUND;
        else drop_entry(at);
      end
      REQ_REMOVE_IDX: begin
        if (int'(pos) >= shadow_count) r.status = ST_RANGE;
        else drop_entry(int'(pos));
      end
      REQ_READ: begin
        if (int'(pos) >= shadow_count) r.status = ST_RANGE;
        else r.read_value = shadow_entries[pos];
      end
      default: r.status = ST_OK;
    endcase
    r.entry_count = 5'(shadow_count);
    return r;
  endfunction

  function automatic void add_step(logic [1:0] req, data_t val, logic [3:0] pos, bit given,
                                   logic [1:0] st, data_t rd, logic [4:0] cnt);
    plan_step_t s;
    s.req = req;
    s.value = val;
    s.position = pos;
    s.given = given;
    s.want.status = st;
    s.want.read_value = rd;
    s.want.entry_count = cnt;
    plan.push_back(s);
  endfunction

  // Values lean toward duplicates, extremes and stored entries
  function automatic data_t draw_value();
    int sel;
    data_t v;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      v = $signed($urandom_range(0, 16)) - 32'sd8;
    end else if (sel < 6) begin
      case ($urandom_range(0, 3))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7FFF_FFFF;
        2: v = 32'sd0;
        default: v = -32'sd1;
      endcase
    end else if (sel < 8 && shadow_count > 0) begin
      v = shadow_entries[$urandom_range(0, shadow_count - 1)];
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  function automatic logic [3:0] draw_position();
    if ($urandom_range(0, 3) != 0)
      return 4'($urandom_range(0, (shadow_count > 15) ? 15 : shadow_count));
    return 4'($urandom_range(0, 15));
  endfunction

  // Drive one request transaction and wait for it to be taken
  task automatic send_request(logic [1:0] req, data_t val, logic [3:0] pos, bit given,
                              result_t want);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= val;
    in_position <= pos;
    want_given  <= given;
    want_result <= want;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  // Let every outstanding result drain
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_order(logic desc);
    drain_results();
    cfg_valid            <= 1'b1;
    cfg_order_descending <= desc;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n_items);
    int k;
    int lean;
    int pct;
    logic [1:0] req;
    result_t blank;
    blank.status = ST_OK;
    blank.read_value = '0;
    blank.entry_count = '0;
    lean = $urandom_range(0, 3);
    for (k = 0; k < n_items; k++) begin
      // wander between draining and filling so both full and empty are hit
      if ($urandom_range(0, 39) == 0) lean = $urandom_range(0, 3);
      if ($urandom_range(0, 59) == 0) steady = !steady;
      pct = 15 + 22 * lean;
      if ($urandom_range(0, 99) < pct) begin
        req = REQ_INSERT;
      end else begin
        case ($urandom_range(0, 2))
          0: req = REQ_REMOVE_VAL;
          1: req = REQ_REMOVE_IDX;
          default: req = REQ_READ;
        endcase
      end
      send_request(req, draw_value(), draw_position(), 1'b0, blank);
    end
  endtask

  // Predict on accepted requests, check accepted results, drive out_stall
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow_desc = cfg_order_descending;
      if (in_valid && !in_stall) begin
        got = apply_request(in_req_type, in_value, in_position);
        pending_results.push_back(want_given ? want_result : got);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, status %0d read_value %0d entry_count %0d",
                   $time, out_status, out_read_value, out_entry_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            errors++;
          end
          if (out_read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d, got %0d",
                     $time, want.read_value, out_read_value);
            errors++;
          end
          if (out_entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d, got %0d",
                     $time, want.entry_count, out_entry_count);
            errors++;
          end
        end
        hold_left = steady ? 0 : $urandom_range(0, 7);
        out_stall <= (hold_left != 0);
      end else if (out_valid && out_stall) begin
        hold_left = hold_left - 1;
        if (hold_left <= 0) out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_array_table_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, ascending order after reset
    add_step(REQ_READ,       32'sh7FFF_FFFF, 4'd0,  1'b1, ST_RANGE,     '0, 5'd0);
    add_step(REQ_REMOVE_IDX, 32'sd0,         4'd15, 1'b1, ST_RANGE,     '0, 5'd0);
    add_step(REQ_REMOVE_VAL, 32'sh8000_0000, 4'd0,  1'b1, ST_NOT_FOUND, '0, 5'd0);
    add_step(REQ_INSERT,     32'sh7FFF_FFFF, 4'd15, 1'b1, ST_OK,        '0, 5'd1);
    add_step(REQ_INSERT,     32'sh8000_0000, 4'd0,  1'b1, ST_OK,        '0, 5'd2);
    add_step(REQ_READ,       32'sd0,         4'd0,  1'b1, ST_OK, 32'sh8000_0000, 5'd2);
    add_step(REQ_READ,       32'sh8000_0000, 4'd1,  1'b1, ST_OK, 32'sh7FFF_FFFF, 5'd2);
    // equal values go ahead of the first equal entry
    add_step(REQ_INSERT,     32'sd0,         4'd0,  1'b0, ST_OK,        '0, 5'd0);
    add_step(REQ_INSERT,     32'sd0,         4'd9,  1'b0, ST_OK,        '0, 5'd0);
    foreach (fill_vals[i]) add_step(REQ_INSERT, fill_vals[i], 4'(i), 1'b0, ST_OK, '0, 5'd0);
    // full table: insert refused, removals still work
    add_step(REQ_INSERT,     32'sd77,        4'd0,  1'b1, ST_FULL,      '0, 5'd16);
    add_step(REQ_REMOVE_VAL, 32'sd0,         4'd3,  1'b1, ST_OK,        '0, 5'd15);
    add_step(REQ_READ,       -32'sd1,        4'd15, 1'b1, ST_RANGE,     '0, 5'd15);
    add_step(REQ_REMOVE_IDX, 32'sh7FFF_FFFF, 4'd0,  1'b0, ST_OK,        '0, 5'd0);
    foreach (plan[i])
      send_request(plan[i].req, plan[i].value, plan[i].position, plan[i].given, plan[i].want);

    // Random phases, flipping the order between them
    for (p = 0; p < RAND_PHASES; p++) begin
      write_order((p % 2) == 0);
      run_random(PHASE_ITEMS);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_array_table_core test passed");
    end else begin
      $display("sorted_array_table_core test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/sat_pkg.sv
hdl/sat_cell.sv
hdl/sorted_array_table_core.sv
tb/sv/sorted_array_table_core_tb.sv
